### hdl/tsu_pkg.sv
package tsu_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_INDEX  = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic {
        FS_RUN = 1'b0,
        FS_MUL = 1'b1
    } t_fstate;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SEQ   = 2'd2;

    localparam logic [2:0] CFG_SLICE_RANK   = 3'd0;
    localparam logic [2:0] CFG_SLICE_SIZE   = 3'd1;
    localparam logic [2:0] CFG_STRIDE_0     = 3'd2;
    localparam logic [2:0] CFG_STRIDE_1     = 3'd3;
    localparam logic [2:0] CFG_STRIDE_2     = 3'd4;
    localparam logic [2:0] CFG_STRIDE_3     = 3'd5;
    localparam logic [2:0] CFG_TENSOR_WORDS = 3'd6;
    localparam logic [2:0] CFG_UPDATE_COUNT = 3'd7;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic        we;
        logic [2:0]  index;
        logic [12:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_op        op;
        logic [1:0] status;
        logic       slice_done;
        logic       all_done;
    } t_ctl;

endpackage

### hdl/tsu_front.sv
module tsu_front #(
    parameter int DEPTH      = 4096,
    parameter int DATA_WIDTH = 32,
    parameter int MAX_RANK   = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [1:0]                i_cmd,
    input  logic [11:0]               i_address,
    input  logic [31:0]               i_data,
    input  logic signed [15:0]        i_index_value,
    input  tsu_pkg::t_cfg_wr          i_cfg,
    output logic                      o_busy,
    output tsu_pkg::t_ctl             o_ctl,
    output logic [$clog2(DEPTH)-1:0]  o_addr,
    output logic [DATA_WIDTH-1:0]     o_data
);
    import tsu_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // configuration
    logic [2:0]  r_rank;
    logic [12:0] r_size;
    logic [12:0] r_stride [4];
    logic [12:0] r_tensor_words;
    logic [12:0] r_update_count;

    // job state
    t_fstate            r_state, n_state;
    logic signed [31:0] r_flat_base, n_flat_base;
    logic [2:0]         r_count, n_count;
    logic [12:0]        r_offset, n_offset;
    logic               r_bad, n_bad;
    logic [12:0]        r_slices, n_slices;
    logic [43:0]        r_word_base;

    logic [2:0]         w_rank;
    logic [12:0]        w_size;
    logic [12:0]        w_limit;
    logic [12:0]        w_stride;
    logic signed [29:0] w_prod;
    logic signed [31:0] w_flat_sum;
    logic [44:0]        w_target;
    logic [13:0]        w_offset_inc;
    logic               w_addr_ok;
    logic               w_jobs_over;
    logic               w_last_index;
    logic [63:0]        w_data_ext;

    always_comb begin
        if (r_rank == 3'd0) begin
            w_rank = 3'd1;
        end else if (r_rank > 3'(MAX_RANK)) begin
            w_rank = 3'(MAX_RANK);
        end else begin
            w_rank = r_rank;
        end
    end

    assign w_size       = (r_size == 13'd0) ? 13'd1 : r_size;
    assign w_limit      = (32'(r_tensor_words) < 32'(DEPTH)) ? r_tensor_words : 13'(DEPTH);
    assign w_stride     = r_stride[r_count[1:0]];
    assign w_prod       = i_index_value * $signed({1'b0, w_stride});
    assign w_flat_sum   = r_flat_base + {{2{w_prod[29]}}, w_prod};
    assign w_target     = {1'b0, r_word_base} + 45'(r_offset);
    assign w_offset_inc = {1'b0, r_offset} + 14'd1;
    assign w_addr_ok    = ({1'b0, i_address} < w_limit);
    assign w_jobs_over  = (r_slices >= r_update_count);
    assign w_data_ext   = 64'(i_data);

    // classify the command and work out the job state after it
    always_comb begin
        n_flat_base       = r_flat_base;
        n_count           = r_count;
        n_offset          = r_offset;
        n_bad             = r_bad;
        n_slices          = r_slices;
        w_last_index      = 1'b0;
        o_ctl.op          = OP_NONE;
        o_ctl.status      = ST_OK;
        o_ctl.slice_done  = 1'b0;
        o_ctl.all_done    = 1'b0;
        o_addr            = '0;
        o_data            = w_data_ext[DATA_WIDTH-1:0];
        if (i_accept) begin
            case (t_cmd'(i_cmd))
                CMD_LOAD, CMD_READ: begin
                    if (w_addr_ok) begin
                        o_ctl.op = (t_cmd'(i_cmd) == CMD_LOAD) ? OP_WRITE : OP_READ;
                        o_addr   = AW'(i_address);
                    end else begin
                        o_ctl.status = ST_RANGE;
                    end
                end
                CMD_INDEX: begin
                    if (w_jobs_over || r_count >= w_rank || r_offset != 13'd0) begin
                        o_ctl.status = ST_SEQ;
                    end else begin
                        n_flat_base = w_flat_sum;
                        n_count     = r_count + 3'd1;
                        if (n_count == w_rank) begin
                            w_last_index = 1'b1;
                            n_bad        = w_flat_sum[31];
                        end
                    end
                end
                CMD_UPDATE: begin
                    if (w_jobs_over || r_count != w_rank) begin
                        o_ctl.status = ST_SEQ;
                    end else begin
                        if (r_bad) begin
                            o_ctl.status = ST_RANGE;
                        end else if (w_target < 45'(w_limit)) begin
                            o_ctl.op = OP_WRITE;
                            o_addr   = AW'(w_target);
                        end else begin
                            o_ctl.status = ST_RANGE;
                        end
                        if (w_offset_inc >= {1'b0, w_size}) begin
                            o_ctl.slice_done = 1'b1;
                            n_offset         = 13'd0;
                            n_count          = 3'd0;
                            n_flat_base      = '0;
                            n_bad            = 1'b0;
                            n_slices         = r_slices + 13'd1;
                            o_ctl.all_done   = (n_slices == r_update_count);
                        end else begin
                            n_offset = w_offset_inc[12:0];
                        end
                    end
                end
                default: ;
            endcase
        end
        // any register write starts a new job
        if (i_cfg.we) begin
            n_flat_base = '0;
            n_count     = 3'd0;
            n_offset    = 13'd0;
            n_bad       = 1'b0;
            n_slices    = 13'd0;
        end
    end

    always_comb begin
        case (r_state)
            FS_RUN:  n_state = (i_accept && w_last_index) ? FS_MUL : FS_RUN;
            FS_MUL:  n_state = FS_RUN;
            default: n_state = FS_RUN;
        endcase
    end

    always_comb begin
        case (r_state)
            FS_MUL:  o_busy = 1'b1;
            default: o_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_RUN;
            r_flat_base <= '0;
            r_count     <= 3'd0;
            r_offset    <= 13'd0;
            r_bad       <= 1'b0;
            r_slices    <= 13'd0;
        end else begin
            r_state     <= n_state;
            r_flat_base <= n_flat_base;
            r_count     <= n_count;
            r_offset    <= n_offset;
            r_bad       <= n_bad;
            r_slices    <= n_slices;
        end
    end

    // word base of the slice, only used when the slice base is not negative
    always_ff @(posedge i_clk) begin
        if (r_state == FS_MUL) begin
            r_word_base <= r_flat_base[30:0] * w_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank         <= 3'd1;
            r_size         <= 13'd1;
            r_stride[0]    <= 13'd1;
            r_stride[1]    <= 13'd1;
            r_stride[2]    <= 13'd1;
            r_stride[3]    <= 13'd1;
            r_tensor_words <= 13'd4096;
            r_update_count <= 13'd1;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_SLICE_RANK:   r_rank         <= i_cfg.data[2:0];
                CFG_SLICE_SIZE:   r_size         <= i_cfg.data;
                CFG_STRIDE_0:     r_stride[0]    <= i_cfg.data;
                CFG_STRIDE_1:     r_stride[1]    <= i_cfg.data;
                CFG_STRIDE_2:     r_stride[2]    <= i_cfg.data;
                CFG_STRIDE_3:     r_stride[3]    <= i_cfg.data;
                CFG_TENSOR_WORDS: r_tensor_words <= i_cfg.data;
                CFG_UPDATE_COUNT: r_update_count <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

### hdl/tsu_queue.sv
module tsu_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_din,
    input  logic         i_pop,
    output logic [W-1:0] o_dout,
    output logic         o_empty,
    output logic         o_full
);
    import tsu_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [W-1:0]  r_mem [Q_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          w_do_pop;

    assign o_empty  = (r_count == CW'(0));
    assign o_full   = (r_count == CW'(Q_DEPTH));
    assign o_dout   = r_mem[r_rptr];
    assign w_do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/tsu_back.sv
module tsu_back #(
    parameter int DEPTH      = 4096,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_pop,
    input  tsu_pkg::t_ctl             i_ctl,
    input  logic [$clog2(DEPTH)-1:0]  i_addr,
    input  logic [DATA_WIDTH-1:0]     i_data,
    output logic                      o_valid,
    output logic [31:0]               o_read_data,
    output logic [1:0]                o_status,
    output logic                      o_slice_done,
    output logic                      o_all_done
);
    import tsu_pkg::*;

    logic [DATA_WIDTH-1:0] r_store [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd;
    logic                  r_valid;
    t_ctl                  r_ctl;
    logic [63:0]           w_rd_ext;

    always_ff @(posedge i_clk) begin
        if (i_pop && i_ctl.op == OP_WRITE) begin
            r_store[i_addr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_rd  <= r_store[i_addr];
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_pop;
        end
    end

    assign w_rd_ext     = 64'(r_rd);
    assign o_valid      = r_valid;
    assign o_read_data  = (r_ctl.op == OP_READ) ? w_rd_ext[31:0] : 32'd0;
    assign o_status     = r_ctl.status;
    assign o_slice_done = r_ctl.slice_done;
    assign o_all_done   = r_ctl.all_done;

endmodule

### hdl/tensor_scatter_update.sv
// o_valid rises once an accepted command has passed the queue register and the
//   back-end result register
// throughput: one command per cycle while o_busy is low; the last index component
//   of a slice holds busy while the slice word base is multiplied out
// reset: synchronous active-low reset clears job state and restores register
//   defaults; store contents stay undefined until loaded, no clearing pass
// results go out unconditionally: the receiver cannot stall
module tensor_scatter_update #(
    parameter int DEPTH      = 4096,
    parameter int DATA_WIDTH = 32,
    parameter int MAX_RANK   = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_cmd,
    input  logic [11:0]        i_address,
    input  logic [31:0]        i_data,
    input  logic signed [15:0] i_index_value,
    output logic               o_valid,
    output logic [31:0]        o_read_data,
    output logic [1:0]         o_status,
    output logic               o_slice_done,
    output logic               o_all_done,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data
);
    import tsu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CTLW = $bits(t_ctl);
    localparam int QW = CTLW + AW + DATA_WIDTH;

    t_cfg_wr               w_cfg;
    logic                  w_accept;
    logic                  w_front_busy;
    t_ctl                  w_f_ctl;
    logic [AW-1:0]         w_f_addr;
    logic [DATA_WIDTH-1:0] w_f_data;
    logic [QW-1:0]         w_q_din, w_q_dout;
    logic                  w_q_empty, w_q_full, w_q_pop;
    t_ctl                  w_b_ctl;
    logic [AW-1:0]         w_b_addr;
    logic [DATA_WIDTH-1:0] w_b_data;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign o_busy   = w_front_busy || w_q_full;
    assign w_accept = i_start && !o_busy;

    tsu_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .MAX_RANK   (MAX_RANK)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_cmd         (i_cmd),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_index_value (i_index_value),
        .i_cfg         (w_cfg),
        .o_busy        (w_front_busy),
        .o_ctl         (w_f_ctl),
        .o_addr        (w_f_addr),
        .o_data        (w_f_data)
    );

    assign w_q_din = {w_f_ctl, w_f_addr, w_f_data};
    assign w_q_pop = !w_q_empty;

    tsu_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_din   (w_q_din),
        .i_pop   (w_q_pop),
        .o_dout  (w_q_dout),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    assign w_b_ctl  = t_ctl'(w_q_dout[QW-1 -: CTLW]);
    assign w_b_addr = w_q_dout[DATA_WIDTH +: AW];
    assign w_b_data = w_q_dout[DATA_WIDTH-1:0];

    tsu_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop        (w_q_pop),
        .i_ctl        (w_b_ctl),
        .i_addr       (w_b_addr),
        .i_data       (w_b_data),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_status     (o_status),
        .o_slice_done (o_slice_done),
        .o_all_done   (o_all_done)
    );

    // every queued transfer comes out as exactly one result the next cycle
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |=> o_valid)
        else $error("queued command produced no result");

    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_pop |=> !o_valid)
        else $error("result without a queued command");

    a_all_done_ends_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_all_done) |-> o_slice_done)
        else $error("all_done without slice_done");

    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_read_data == 32'd0))
        else $error("read data on a failed command");

endmodule
